FILE: hdl/quaternion_rotation_accumulator_top_defines.svh
// Assertion macros for the quaternion rotation accumulator.
`ifndef QUATERNION_ROTATION_ACCUMULATOR_TOP_DEFINES_SVH
`define QUATERNION_ROTATION_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QRA_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("qra: same-cycle check failed");
`define QRA_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("qra: next-cycle check failed");
`else
`define QRA_ASSERT_IMP(label, cond, prop)
`define QRA_ASSERT_NXT(label, cond, prop)
`endif

`endif

FILE: hdl/qra_pkg.sv
// Types, constants and saturating arithmetic for the quaternion rotation accumulator.
package qra_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 30;
    localparam int PROD_BITS = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t ONE = (FRAC_BITS < WORD_BITS - 1) ?
                            word_t'(prod_t'(1) << FRAC_BITS) : WORD_MAX;
    localparam prod_t PROD_BIAS = (prod_t'(1) << FRAC_BITS) - prod_t'(1);
    localparam prod_t PROD_MAX = prod_t'(WORD_MAX);
    localparam prod_t PROD_MIN = prod_t'(WORD_MIN);

    typedef struct packed {
        logic  mode;
        word_t rot_w;
        word_t rot_x;
        word_t rot_y;
        word_t rot_z;
    } rot_item_t;

    typedef struct packed {
        word_t m11;
        word_t m12;
        word_t m13;
        word_t m21;
        word_t m22;
        word_t m23;
        word_t m31;
        word_t m32;
        word_t m33;
    } mat_item_t;

    typedef struct packed {
        word_t w;
        word_t x;
        word_t y;
        word_t z;
    } quat_t;

    // Multiplier passes: four quaternion components, then the matrix products.
    typedef enum logic [2:0] {
        STEP_QW,
        STEP_QX,
        STEP_QY,
        STEP_QZ,
        STEP_SQ,
        STEP_CROSS,
        STEP_YZWX
    } step_t;

    typedef struct packed {
        logic  capture;
        logic  issue;
        step_t step;
        logic  load_nq;
        logic  commit;
        logic  load_out;
    } cmd_t;

    typedef struct packed {
        logic quat_done;
        logic mat_done;
    } status_t;

    function automatic word_t sat_add(word_t a, word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return word_t'(s[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_sub(word_t a, word_t b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        return word_t'(s[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_acc(word_t a, word_t b, logic neg);
        return neg ? sat_sub(a, b) : sat_add(a, b);
    endfunction

    // Shift out the fraction rounding toward zero, then clamp to the word.
    function automatic word_t sat_prod(prod_t p);
        prod_t t;
        t = p[PROD_BITS-1] ? p + PROD_BIAS : p;
        t = t >>> FRAC_BITS;
        if (t > PROD_MAX)
            return WORD_MAX;
        if (t < PROD_MIN)
            return WORD_MIN;
        return word_t'(t[WORD_BITS-1:0]);
    endfunction

endpackage

FILE: hdl/qra_datapath.sv
// Datapath: operand select, four multipliers, saturation and the combining adders.
module qra_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  qra_pkg::cmd_t      cmd,
    input  qra_pkg::rot_item_t rot,
    output qra_pkg::status_t   status,
    output qra_pkg::mat_item_t mat
);

    qra_pkg::rot_item_t in_reg;
    qra_pkg::quat_t     orient_reg;
    qra_pkg::quat_t     nq_reg;
    qra_pkg::word_t     opa [4];
    qra_pkg::word_t     opb [4];
    qra_pkg::prod_t     p_next [4];
    qra_pkg::prod_t     p_reg [4];
    qra_pkg::word_t     s_reg [4];
    qra_pkg::word_t     d [4];
    logic               t1_valid_reg;
    qra_pkg::step_t     t1_step_reg;
    logic               t2_valid_reg;
    qra_pkg::step_t     t2_step_reg;
    logic [2:0]         neg;
    qra_pkg::word_t     q_sum;
    qra_pkg::mat_item_t mat_reg;
    qra_pkg::mat_item_t out_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            opa[i] = '0;
            opb[i] = '0;
        end
        unique case (cmd.step)
            qra_pkg::STEP_QW:
            begin
                opa = '{in_reg.rot_w, in_reg.rot_x, in_reg.rot_y, in_reg.rot_z};
                opb = '{orient_reg.w, orient_reg.x, orient_reg.y, orient_reg.z};
            end
            qra_pkg::STEP_QX:
            begin
                opa = '{in_reg.rot_w, in_reg.rot_x, in_reg.rot_y, in_reg.rot_z};
                opb = '{orient_reg.x, orient_reg.w, orient_reg.z, orient_reg.y};
            end
            qra_pkg::STEP_QY:
            begin
                opa = '{in_reg.rot_w, in_reg.rot_x, in_reg.rot_y, in_reg.rot_z};
                opb = '{orient_reg.y, orient_reg.z, orient_reg.w, orient_reg.x};
            end
            qra_pkg::STEP_QZ:
            begin
                opa = '{in_reg.rot_w, in_reg.rot_x, in_reg.rot_y, in_reg.rot_z};
                opb = '{orient_reg.z, orient_reg.y, orient_reg.x, orient_reg.w};
            end
            qra_pkg::STEP_SQ:
            begin
                opa = '{nq_reg.w, nq_reg.x, nq_reg.y, nq_reg.z};
                opb = '{nq_reg.w, nq_reg.x, nq_reg.y, nq_reg.z};
            end
            qra_pkg::STEP_CROSS:
            begin
                opa = '{nq_reg.x, nq_reg.w, nq_reg.x, nq_reg.w};
                opb = '{nq_reg.y, nq_reg.z, nq_reg.z, nq_reg.y};
            end
            qra_pkg::STEP_YZWX:
            begin
                opa = '{nq_reg.y, nq_reg.w, '0, '0};
                opb = '{nq_reg.z, nq_reg.x, '0, '0};
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 4; i++)
            p_next[i] = opa[i] * opb[i];
    end

    // signs of the three accumulations for each quaternion component
    always_comb
    begin
        unique case (t2_step_reg)
            qra_pkg::STEP_QW: neg = 3'b111;
            qra_pkg::STEP_QX: neg = 3'b001;
            qra_pkg::STEP_QY: neg = 3'b100;
            qra_pkg::STEP_QZ: neg = 3'b010;
            default:          neg = 3'b000;
        endcase
        q_sum = qra_pkg::sat_acc(qra_pkg::sat_acc(qra_pkg::sat_acc(s_reg[0], s_reg[1], neg[2]),
                                 s_reg[2], neg[1]), s_reg[3], neg[0]);
        for (int i = 0; i < 4; i++)
            d[i] = qra_pkg::sat_add(s_reg[i], s_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orient_reg   <= '{w: qra_pkg::ONE, x: '0, y: '0, z: '0};
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
                orient_reg <= nq_reg;
            t1_valid_reg <= cmd.issue;
            t2_valid_reg <= t1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= rot;
        for (int i = 0; i < 4; i++)
        begin
            p_reg[i] <= p_next[i];
            s_reg[i] <= qra_pkg::sat_prod(p_reg[i]);
        end
        t1_step_reg <= cmd.step;
        t2_step_reg <= t1_step_reg;

        if (cmd.load_nq)
            nq_reg <= '{w: in_reg.rot_w, x: in_reg.rot_x, y: in_reg.rot_y, z: in_reg.rot_z};
        else if (t2_valid_reg)
        begin
            unique case (t2_step_reg)
                qra_pkg::STEP_QW: nq_reg.w <= q_sum;
                qra_pkg::STEP_QX: nq_reg.x <= q_sum;
                qra_pkg::STEP_QY: nq_reg.y <= q_sum;
                qra_pkg::STEP_QZ: nq_reg.z <= q_sum;
                default:
                begin
                end
            endcase
        end

        if (t2_valid_reg)
        begin
            unique case (t2_step_reg)
                qra_pkg::STEP_SQ:
                begin
                    mat_reg.m11 <= qra_pkg::sat_sub(qra_pkg::sat_sub(
                                   qra_pkg::sat_add(s_reg[0], s_reg[1]), s_reg[2]), s_reg[3]);
                    mat_reg.m22 <= qra_pkg::sat_sub(qra_pkg::sat_add(
                                   qra_pkg::sat_sub(s_reg[0], s_reg[1]), s_reg[2]), s_reg[3]);
                    mat_reg.m33 <= qra_pkg::sat_add(qra_pkg::sat_sub(
                                   qra_pkg::sat_sub(s_reg[0], s_reg[1]), s_reg[2]), s_reg[3]);
                end
                qra_pkg::STEP_CROSS:
                begin
                    mat_reg.m12 <= qra_pkg::sat_sub(d[0], d[1]);
                    mat_reg.m21 <= qra_pkg::sat_add(d[0], d[1]);
                    mat_reg.m13 <= qra_pkg::sat_add(d[2], d[3]);
                    mat_reg.m31 <= qra_pkg::sat_sub(d[2], d[3]);
                end
                qra_pkg::STEP_YZWX:
                begin
                    mat_reg.m23 <= qra_pkg::sat_sub(d[0], d[1]);
                    mat_reg.m32 <= qra_pkg::sat_add(d[0], d[1]);
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.load_out)
            out_reg <= mat_reg;
    end

    assign status.quat_done = t2_valid_reg && (t2_step_reg == qra_pkg::STEP_QZ);
    assign status.mat_done  = t2_valid_reg && (t2_step_reg == qra_pkg::STEP_YZWX);
    assign mat              = out_reg;

endmodule

FILE: hdl/qra_ctrl.sv
// Controller: sequences the multiplier passes and owns both handshakes.
module qra_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rot_valid,
    input  logic             mode,
    input  logic             mat_stall,
    input  qra_pkg::status_t status,
    output qra_pkg::cmd_t    cmd,
    output logic             rot_stall,
    output logic             mat_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROT,
        S_ROT_WAIT,
        S_MAT,
        S_MAT_WAIT,
        S_DONE
    } state_t;

    state_t         state_reg;
    state_t         state_next;
    qra_pkg::step_t step_reg;
    qra_pkg::step_t step_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           load_out;

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !mat_stall);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rot_valid)
                begin
                    if (mode)
                        state_next = S_LOAD;
                    else
                    begin
                        state_next = S_ROT;
                        step_next  = qra_pkg::STEP_QW;
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_MAT;
                step_next  = qra_pkg::STEP_SQ;
            end
            S_ROT:
            begin
                if (step_reg == qra_pkg::STEP_QZ)
                    state_next = S_ROT_WAIT;
                else
                    step_next = qra_pkg::step_t'(step_reg + 3'd1);
            end
            S_ROT_WAIT:
            begin
                if (status.quat_done)
                begin
                    state_next = S_MAT;
                    step_next  = qra_pkg::STEP_SQ;
                end
            end
            S_MAT:
            begin
                if (step_reg == qra_pkg::STEP_YZWX)
                    state_next = S_MAT_WAIT;
                else
                    step_next = qra_pkg::step_t'(step_reg + 3'd1);
            end
            S_MAT_WAIT:
            begin
                if (status.mat_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        priority if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !mat_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= qra_pkg::STEP_QW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd.capture  = (state_reg == S_IDLE);
    assign cmd.issue    = (state_reg == S_ROT) || (state_reg == S_MAT);
    assign cmd.step     = step_reg;
    assign cmd.load_nq  = (state_reg == S_LOAD);
    assign cmd.commit   = (state_reg == S_MAT) && (step_reg == qra_pkg::STEP_SQ);
    assign cmd.load_out = load_out;
    assign rot_stall    = (state_reg != S_IDLE);
    assign mat_valid    = out_valid_reg;

endmodule

FILE: hdl/quaternion_rotation_accumulator_top.sv
// Top level of the quaternion rotation accumulator.
//
// Input channel rot (rot_valid / rot_stall / rot): one item per orientation update.
// mode 0 multiplies the item's quaternion onto the stored orientation (item * stored),
// mode 1 loads it as the new orientation. All words are signed Q2.30.
// Output channel mat (mat_valid / mat_stall / mat): one item per input item, the
// 3x3 rotation matrix of the new orientation, saturated Q2.30.
// One item is in work at a time. The four multipliers are shared and feed a
// two-stage product/saturate pipe: four passes for the quaternion product, which
// must complete before the three matrix passes can start.
// A finished matrix sits in the output register while the next item is taken, and
// is only replaced once the receiver has taken it; a stall on mat holds the item
// and, once the next result is ready, holds off further input.
// Reset sets the orientation to identity and empties both channels.
`include "quaternion_rotation_accumulator_top_defines.svh"

module quaternion_rotation_accumulator_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rot_valid,
    output logic               rot_stall,
    input  qra_pkg::rot_item_t rot,
    output logic               mat_valid,
    input  logic               mat_stall,
    output qra_pkg::mat_item_t mat
);

    qra_pkg::cmd_t    cmd;
    qra_pkg::status_t status;

    qra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .rot_valid (rot_valid),
        .mode      (rot.mode),
        .mat_stall (mat_stall),
        .status    (status),
        .cmd       (cmd),
        .rot_stall (rot_stall),
        .mat_valid (mat_valid)
    );

    qra_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .rot    (rot),
        .status (status),
        .mat    (mat)
    );

    `QRA_ASSERT_NXT(a_busy_after_accept, rot_valid && !rot_stall, rot_stall)
    `QRA_ASSERT_NXT(a_load_out_valid, cmd.load_out, mat_valid)
    `QRA_ASSERT_IMP(a_done_while_busy, status.mat_done || status.quat_done, rot_stall)
    `QRA_ASSERT_IMP(a_load_not_issue, cmd.load_nq, !cmd.issue)

endmodule

FILE: bench/quaternion_rotation_accumulator_top_test.sv
// Testbench for the quaternion rotation accumulator: directed and random items.
`timescale 1ns / 1ps

module quaternion_rotation_accumulator_top_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;
    localparam qra_pkg::word_t C45 = 32'sd759250125;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rot_valid = 1'b0;
    logic rot_stall;
    qra_pkg::rot_item_t rot = '0;
    logic mat_valid;
    logic mat_stall = 1'b0;
    qra_pkg::mat_item_t mat;

    bit idling = 1'b1;
    int fail_count = 0;
    qra_pkg::quat_t orient = '{w: qra_pkg::ONE, x: '0, y: '0, z: '0};
    qra_pkg::mat_item_t pending_matrices[$];
    qra_pkg::mat_item_t want;
    string entry_names[9] = '{"m11", "m12", "m13", "m21", "m22", "m23", "m31", "m32", "m33"};

    quaternion_rotation_accumulator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rot_valid (rot_valid),
        .rot_stall (rot_stall),
        .rot       (rot),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat)
    );

    always #10 clk = ~clk;

    function automatic qra_pkg::word_t fx_clamp(longint v);
        if (v > longint'(qra_pkg::WORD_MAX))
            return qra_pkg::WORD_MAX;
        if (v < longint'(qra_pkg::WORD_MIN))
            return qra_pkg::WORD_MIN;
        return qra_pkg::word_t'(v);
    endfunction

    function automatic qra_pkg::word_t fx_add(qra_pkg::word_t a, qra_pkg::word_t b);
        return fx_clamp(longint'(a) + longint'(b));
    endfunction

    function automatic qra_pkg::word_t fx_sub(qra_pkg::word_t a, qra_pkg::word_t b);
        return fx_clamp(longint'(a) - longint'(b));
    endfunction

    // truncate toward zero
    function automatic qra_pkg::word_t fx_mul(qra_pkg::word_t a, qra_pkg::word_t b);
        longint p;
        longint q;
        p = longint'(a) * longint'(b);
        q = (p < 0) ? -((-p) >>> qra_pkg::FRAC_BITS) : (p >>> qra_pkg::FRAC_BITS);
        return fx_clamp(q);
    endfunction

    function automatic qra_pkg::word_t fx_twice(qra_pkg::word_t a, qra_pkg::word_t b);
        qra_pkg::word_t p;
        p = fx_mul(a, b);
        return fx_add(p, p);
    endfunction

    function automatic qra_pkg::mat_item_t apply_update(qra_pkg::rot_item_t it);
        qra_pkg::quat_t b;
        qra_pkg::quat_t n;
        qra_pkg::word_t ww, xx, yy, zz;
        qra_pkg::mat_item_t m;
        b = orient;
        if (it.mode)
        begin
            n = '{w: it.rot_w, x: it.rot_x, y: it.rot_y, z: it.rot_z};
        end
        else
        begin
            n.w = fx_sub(fx_sub(fx_sub(fx_mul(it.rot_w, b.w), fx_mul(it.rot_x, b.x)),
                                fx_mul(it.rot_y, b.y)), fx_mul(it.rot_z, b.z));
            n.x = fx_sub(fx_add(fx_add(fx_mul(it.rot_w, b.x), fx_mul(it.rot_x, b.w)),
                                fx_mul(it.rot_y, b.z)), fx_mul(it.rot_z, b.y));
            n.y = fx_add(fx_add(fx_sub(fx_mul(it.rot_w, b.y), fx_mul(it.rot_x, b.z)),
                                fx_mul(it.rot_y, b.w)), fx_mul(it.rot_z, b.x));
            n.z = fx_add(fx_sub(fx_add(fx_mul(it.rot_w, b.z), fx_mul(it.rot_x, b.y)),
                                fx_mul(it.rot_y, b.x)), fx_mul(it.rot_z, b.w));
        end
        orient = n;
        ww = fx_mul(n.w, n.w);
        xx = fx_mul(n.x, n.x);
        yy = fx_mul(n.y, n.y);
        zz = fx_mul(n.z, n.z);
        m.m11 = fx_sub(fx_sub(fx_add(ww, xx), yy), zz);
        m.m12 = fx_sub(fx_twice(n.x, n.y), fx_twice(n.w, n.z));
        m.m13 = fx_add(fx_twice(n.x, n.z), fx_twice(n.w, n.y));
        m.m21 = fx_add(fx_twice(n.x, n.y), fx_twice(n.w, n.z));
        m.m22 = fx_sub(fx_add(fx_sub(ww, xx), yy), zz);
        m.m23 = fx_sub(fx_twice(n.y, n.z), fx_twice(n.w, n.x));
        m.m31 = fx_sub(fx_twice(n.x, n.z), fx_twice(n.w, n.y));
        m.m32 = fx_add(fx_twice(n.y, n.z), fx_twice(n.w, n.x));
        m.m33 = fx_add(fx_sub(fx_sub(ww, xx), yy), zz);
        return m;
    endfunction

    function automatic qra_pkg::word_t edge_word();
        unique case ($urandom_range(0, 5))
            0: return qra_pkg::WORD_MAX;
            1: return qra_pkg::WORD_MIN;
            2: return '0;
            3: return qra_pkg::ONE;
            4: return -qra_pkg::ONE;
            default: return '1;
        endcase
    endfunction

    function automatic qra_pkg::word_t unit_word();
        return qra_pkg::word_t'($urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
    endfunction

    function automatic qra_pkg::word_t small_word();
        return qra_pkg::word_t'($urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
    endfunction

    function automatic qra_pkg::rot_item_t random_rotation();
        qra_pkg::rot_item_t it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            it.mode = 1'($urandom_range(0, 1));
            it.rot_w = qra_pkg::word_t'($urandom);
            it.rot_x = qra_pkg::word_t'($urandom);
            it.rot_y = qra_pkg::word_t'($urandom);
            it.rot_z = qra_pkg::word_t'($urandom);
        end
        else if (pick < 16)
        begin
            it.mode = 1'($urandom_range(0, 1));
            it.rot_w = edge_word();
            it.rot_x = edge_word();
            it.rot_y = edge_word();
            it.rot_z = edge_word();
        end
        else if (pick < 28)
        begin
            it.mode = 1'b1;
            it.rot_w = unit_word();
            it.rot_x = unit_word();
            it.rot_y = unit_word();
            it.rot_z = unit_word();
        end
        else
        begin
            // small rotation, close to unit length
            it.mode = 1'b0;
            it.rot_w = qra_pkg::word_t'(qra_pkg::ONE -
                       qra_pkg::word_t'($urandom_range(0, 32'h0100_0000)));
            if ($urandom_range(0, 3) == 0)
                it.rot_w = -it.rot_w;
            it.rot_x = small_word();
            it.rot_y = small_word();
            it.rot_z = small_word();
        end
        return it;
    endfunction

    task automatic send_rotation(qra_pkg::rot_item_t it);
        while (idling && $urandom_range(0, 99) < 11)
        begin
            rot_valid <= 1'b0;
            @(posedge clk);
        end
        rot_valid <= 1'b1;
        rot <= it;
        @(posedge clk);
        while (rot_stall)
            @(posedge clk);
        pending_matrices.push_back(apply_update(it));
    endtask

    task automatic wait_drained();
        while (pending_matrices.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        idling = 1'b1;
        send_rotation('{1'b0, qra_pkg::ONE, '0, '0, '0});
        send_rotation('{1'b0, C45, '0, '0, C45});
        send_rotation('{1'b0, C45, C45, '0, '0});
        send_rotation('{1'b0, C45, '0, C45, '0});
        send_rotation('{1'b0, -qra_pkg::ONE, '0, '0, '0});
        send_rotation('{1'b1, qra_pkg::WORD_MAX, qra_pkg::WORD_MAX, qra_pkg::WORD_MAX,
                       qra_pkg::WORD_MAX});
        send_rotation('{1'b1, qra_pkg::WORD_MIN, qra_pkg::WORD_MIN, qra_pkg::WORD_MIN,
                       qra_pkg::WORD_MIN});
        send_rotation('{1'b1, '0, '0, '0, '0});
        send_rotation('{1'b0, qra_pkg::ONE, '0, '0, '0});
        // minus two squared saturates
        send_rotation('{1'b1, qra_pkg::WORD_MIN, '0, '0, '0});
        send_rotation('{1'b0, qra_pkg::WORD_MIN, '0, '0, '0});
        send_rotation('{1'b0, qra_pkg::WORD_MAX, qra_pkg::WORD_MIN, qra_pkg::WORD_MAX,
                       qra_pkg::WORD_MIN});
        // tiny values: negative products truncate to zero
        send_rotation('{1'b1, qra_pkg::word_t'(1), qra_pkg::word_t'(-1), qra_pkg::word_t'(3),
                       qra_pkg::word_t'(-5)});
        send_rotation('{1'b1, qra_pkg::ONE, qra_pkg::ONE, -qra_pkg::ONE, qra_pkg::ONE});
        send_rotation('{1'b0, qra_pkg::word_t'(-357913941), qra_pkg::word_t'(123456789),
                       qra_pkg::word_t'(-987654321), qra_pkg::word_t'(55555555)});
        send_rotation('{1'b0, C45, -C45, '0, '0});
        send_rotation('{1'b1, qra_pkg::ONE, '0, '0, '0});
    endtask

    task automatic test_random_updates(int count);
        idling = 1'b1;
        repeat (count)
            send_rotation(random_rotation());
    endtask

    task automatic test_back_to_back(int count);
        idling = 1'b0;
        repeat (count)
            send_rotation(random_rotation());
        idling = 1'b1;
    endtask

    task automatic test_drain_pause(int count);
        idling = 1'b1;
        repeat (count / 2)
            send_rotation(random_rotation());
        rot_valid <= 1'b0;
        wait_drained();
        repeat (count - count / 2)
            send_rotation(random_rotation());
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            mat_stall <= 1'b0;
        else
            mat_stall <= idling && ($urandom_range(0, 99) < 11);
    end

    always @(posedge clk)
    begin
        if (rst_n && mat_valid && !mat_stall)
        begin
            if (pending_matrices.size() == 0)
            begin
                fail_count++;
                $display("%0t: matrix item with nothing expected, got %h", $time, mat);
            end
            else
            begin
                want = pending_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    if (mat[(8 - i) * qra_pkg::WORD_BITS +: qra_pkg::WORD_BITS] !==
                        want[(8 - i) * qra_pkg::WORD_BITS +: qra_pkg::WORD_BITS])
                    begin
                        fail_count++;
                        $display("%0t: %s expected %h got %h", $time, entry_names[i],
                                 want[(8 - i) * qra_pkg::WORD_BITS +: qra_pkg::WORD_BITS],
                                 mat[(8 - i) * qra_pkg::WORD_BITS +: qra_pkg::WORD_BITS]);
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT)
            @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_updates(900);
        test_back_to_back(300);
        test_drain_pause(250);
        rot_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending_matrices.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
